/* rtl/core/row_correlation_matrix_core_macros.svh */
// Assertion helpers; the asserting module provides clk and rst_n.
`ifndef ROW_CORRELATION_MATRIX_CORE_MACROS_SVH
`define ROW_CORRELATION_MATRIX_CORE_MACROS_SVH

// Same-cycle implication.
`define RCM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RCM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/rcm_pkg.sv */
package rcm_pkg;

  localparam int MAX_ROWS_DEF = 8;
  localparam int MAX_COLS_DEF = 256;

  localparam int SAMPLE_W   = 32;
  localparam int CORR_W     = 32;
  localparam int IDX_W      = 3;
  localparam int ROWCNT_W   = 4;
  localparam int COLCNT_W   = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAFE_MODE = 2'd2;

  localparam int SC_W   = 25;
  localparam int UQ_W   = 31;
  localparam int UNIT_W = 32;
  localparam int ACC_W  = 64;
  localparam int FRAC_W = 30;

  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint EPS_Q30 = 64'sd10737;
  localparam longint CORR_MAX = 64'sd2147483647;
  localparam longint CORR_MIN = -64'sd2147483648;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  typedef enum logic [11:0] {
    S_LOAD  = 12'b0000_0000_0001,
    S_SUM   = 12'b0000_0000_0010,
    S_DEV   = 12'b0000_0000_0100,
    S_SCALE = 12'b0000_0000_1000,
    S_SQ    = 12'b0000_0001_0000,
    S_SQRT  = 12'b0000_0010_0000,
    S_DIV   = 12'b0000_0100_0000,
    S_NEXT  = 12'b0000_1000_0000,
    S_DOT   = 12'b0001_0000_0000,
    S_FIN   = 12'b0010_0000_0000,
    S_OUT   = 12'b0100_0000_0000,
    S_ERR   = 12'b1000_0000_0000
  } state_t;

endpackage

/* rtl/core/row_correlation_matrix_core.sv */
// Row correlation matrix core.
// Program row_count, col_count and safe_mode over the cfg_ write channel while
// the core is loading (cfg_ready high). Stream the matrix in row-major order on
// in_valid/in_sample, one Q16.16 word per cycle; in_stall stays low while loading.
// After the last word the core raises in_stall and computes: per row a sum, the
// centred and scaled words, their square root norm and a divide per column in the
// bit-serial divider (one quotient bit per cycle), or zeros for a flat row; per
// output pair a single shared 32x32 multiply-accumulate. The matrix then
// leaves as rows*rows Q2.30 words, row-major, with row_index/col_index, last_flag on
// the final word. A degenerate row without safe_mode gives a single word with
// error_flag and last_flag set.
// While out_stall is high a valid output word holds and the sequencer waits before loading the next.
// After the final word is registered the core takes new samples again.
// Reset clears the load count, the sequencer and the output valid and sets the
// registers to row_count 1, col_count 2, safe_mode 0; the sample store keeps its
// contents and needs no clearing pass.
`include "row_correlation_matrix_core_macros.svh"
module row_correlation_matrix_core import rcm_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [CORR_W-1:0]   out_correlation,
  output logic [IDX_W-1:0]           out_row_index,
  output logic [IDX_W-1:0]           out_col_index,
  output logic                       out_error_flag,
  output logic                       out_last_flag,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  localparam int ROW_W  = $clog2(MAX_ROWS + 1);
  localparam int RI_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W  = $clog2(MAX_COLS + 1);
  localparam int CI_W   = $clog2(MAX_COLS);
  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = SAMPLE_W + COL_W;
  localparam int PROD_W = SAMPLE_W + COL_W + 1;
  localparam int DW     = SAMPLE_W + COL_W + 2;
  localparam int SH_W   = $clog2(DW + 1);
  localparam int QW     = 2 * SC_W + COL_W;
  localparam int QW2    = QW + (QW % 2);
  localparam int NRM_W  = QW2 / 2;
  localparam int RW     = ACC_W - FRAC_W;

  localparam logic [DW-1:0]           SC_TOP  = DW'(1) << SC_W;
  localparam logic signed [ACC_W-1:0] HALF_A  = ACC_W'(ONE_Q30 >>> 1);
  localparam logic signed [RW-1:0]    ONE_R   = RW'(ONE_Q30);
  localparam logic signed [RW-1:0]    EPS_R   = RW'(EPS_Q30);
  localparam logic signed [RW-1:0]    ONE_HI  = ONE_R + EPS_R;
  localparam logic signed [RW-1:0]    ONE_LO  = -ONE_R - EPS_R;
  localparam logic signed [RW-1:0]    CMAX_R  = RW'(CORR_MAX);
  localparam logic signed [RW-1:0]    CMIN_R  = RW'(CORR_MIN);

  state_t state_r;

  logic [ROWCNT_W-1:0] row_count_r;
  logic [COLCNT_W-1:0] col_count_r;
  logic                safe_mode_r;
  logic [ROW_W-1:0]    rows_eff;
  logic [COL_W-1:0]    cols_eff;
  logic [CNT_W-1:0]    total, cnt_inc, load_cnt_r;

  logic [SAMPLE_W-1:0]       store_mem [DEPTH];
  logic signed [UNIT_W-1:0]  unit_mem  [DEPTH];

  logic              in_acc;
  logic [CI_W-1:0]   col_r;
  logic              col_last, iss_done_r, issue;
  logic [RI_W-1:0]   row_r, a_r, b_r;
  logic [ADDR_W-1:0] base_r, base_a_r, base_b_r, rd_addr, rb_addr;

  logic                      v1_r, v2_r, v3_r, v4_r, v5_r;
  logic                      l1_r, l2_r, l3_r, l4_r, l5_r;
  logic [ADDR_W-1:0]         a1_r, a2_r, a3_r, a4_r;
  logic                      neg3_r, neg4_r, flush;
  logic signed [SAMPLE_W-1:0] rd_data_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [DW-1:0]      dev;
  logic [DW-1:0]             mag_r, m_r, m_fin, shv;
  logic [SH_W-1:0]           right_r, left_r;
  logic [SC_W-1:0]           sc_r;
  logic [2*SC_W-1:0]         sq_r;
  logic signed [SUM_W-1:0]   sum_r;
  logic [QW-1:0]             q_r;
  logic                      deg_r, any_deg_r;

  logic              sqrt_go_r;
  logic [NRM_W-1:0]  sqrt_root, norm_r;
  unit_sts_t         sqrt_sts, div_sts;
  logic              div_start, elem_busy_r, div_neg_r, div_last_r;
  logic [ADDR_W-1:0] div_addr_r;
  logic [UQ_W-1:0]   div_quot;

  logic                     uw_en;
  logic [ADDR_W-1:0]        uw_addr;
  logic signed [UNIT_W-1:0] uw_data;

  logic                      p1_r, p2_r, pl1_r, pl2_r;
  logic signed [UNIT_W-1:0]  ua_r, ub_r;
  logic signed [ACC_W-1:0]   pr_r, acc_r, acc_rnd;
  logic signed [RW-1:0]      r_r;
  logic signed [CORR_W-1:0]  corr_val;
  logic                      pair_last, out_free, out_load;

  logic                      out_valid_r, out_err_r, out_last_r;
  logic signed [CORR_W-1:0]  out_corr_r;
  logic [IDX_W-1:0]          out_row_r, out_col_r;

  always_comb begin
    if (row_count_r == '0) begin
      rows_eff = ROW_W'(1);
    end else if (32'(row_count_r) > 32'(MAX_ROWS)) begin
      rows_eff = ROW_W'(MAX_ROWS);
    end else begin
      rows_eff = ROW_W'(row_count_r);
    end
    if (col_count_r == '0) begin
      cols_eff = COL_W'(1);
    end else if (32'(col_count_r) > 32'(MAX_COLS)) begin
      cols_eff = COL_W'(MAX_COLS);
    end else begin
      cols_eff = COL_W'(col_count_r);
    end
  end

  assign total     = CNT_W'(rows_eff) * CNT_W'(cols_eff);
  assign cnt_inc   = load_cnt_r + 1'b1;
  assign in_stall  = state_r != S_LOAD;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = state_r == S_LOAD;

  assign col_last  = col_r == CI_W'(cols_eff - 1'b1);
  assign rd_addr   = ((state_r == S_DOT) ? base_a_r : base_r) + ADDR_W'(col_r);
  assign rb_addr   = base_b_r + ADDR_W'(col_r);
  assign pair_last = (a_r == RI_W'(rows_eff - 1'b1)) && (b_r == RI_W'(rows_eff - 1'b1));

  always_comb begin
    case (state_r)
      S_SUM, S_DEV, S_SQ, S_DOT: issue = !iss_done_r;
      S_DIV:                     issue = !deg_r && !iss_done_r && !elem_busy_r;
      default:                   issue = 1'b0;
    endcase
  end

  assign flush = (state_r == S_SUM && v1_r && l1_r) || (state_r == S_DEV && v3_r && l3_r);

  assign dev   = DW'(prod_r) - DW'(sum_r);
  assign m_fin = (mag_r > m_r) ? mag_r : m_r;
  assign shv   = (mag_r >> right_r) << left_r;

  assign div_start = v4_r && state_r == S_DIV;
  assign uw_en     = (state_r == S_DIV) && (deg_r || div_sts.done);
  assign uw_addr   = deg_r ? rd_addr : div_addr_r;
  assign uw_data   = deg_r ? '0 :
                     (div_neg_r ? -UNIT_W'(div_quot) : UNIT_W'(div_quot));

  assign acc_rnd = acc_r + HALF_A;

  always_comb begin
    if (r_r > ONE_R && r_r <= ONE_HI) begin
      corr_val = CORR_W'(ONE_R);
    end else if (r_r < -ONE_R && r_r >= ONE_LO) begin
      corr_val = -CORR_W'(ONE_R);
    end else if (r_r > CMAX_R) begin
      corr_val = CORR_W'(CMAX_R);
    end else if (r_r < CMIN_R) begin
      corr_val = CORR_W'(CMIN_R);
    end else begin
      corr_val = CORR_W'(r_r);
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == S_OUT || state_r == S_ERR) && out_free;

  always_ff @(posedge clk) begin
    if (in_acc && load_cnt_r < CNT_W'(DEPTH)) begin
      store_mem[load_cnt_r[ADDR_W-1:0]] <= in_sample;
    end
    if (issue && state_r != S_DOT) begin
      rd_data_r <= store_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (uw_en) begin
      unit_mem[uw_addr] <= uw_data;
    end
    if (issue && state_r == S_DOT) begin
      ua_r <= unit_mem[rd_addr];
      ub_r <= unit_mem[rb_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      p1_r <= 1'b0;
      p2_r <= 1'b0;
    end else if (flush) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= issue && state_r != S_DOT;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      p1_r <= issue && state_r == S_DOT;
      p2_r <= p1_r;
    end
  end

  always_ff @(posedge clk) begin
    l1_r   <= col_last;
    a1_r   <= rd_addr;
    l2_r   <= l1_r;
    a2_r   <= a1_r;
    prod_r <= rd_data_r * $signed({1'b0, cols_eff});
    l3_r   <= l2_r;
    a3_r   <= a2_r;
    neg3_r <= dev[DW-1];
    mag_r  <= dev[DW-1] ? DW'(-dev) : DW'(dev);
    l4_r   <= l3_r;
    a4_r   <= a3_r;
    neg4_r <= neg3_r;
    sc_r   <= shv[SC_W-1:0];
    l5_r   <= l4_r;
    sq_r   <= sc_r * sc_r;
    pl1_r  <= col_last;
    pl2_r  <= pl1_r;
    pr_r   <= ua_r * ub_r;
    if (div_start) begin
      div_addr_r <= a4_r;
      div_neg_r  <= neg4_r;
      div_last_r <= l4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      row_count_r <= ROWCNT_W'(1);
      col_count_r <= COLCNT_W'(2);
      safe_mode_r <= 1'b0;
      load_cnt_r  <= '0;
      col_r       <= '0;
      iss_done_r  <= 1'b0;
      elem_busy_r <= 1'b0;
      sqrt_go_r   <= 1'b0;
      deg_r       <= 1'b0;
      any_deg_r   <= 1'b0;
      row_r       <= '0;
      a_r         <= '0;
      b_r         <= '0;
    end else begin
      sqrt_go_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ROW_COUNT: row_count_r <= cfg_data[ROWCNT_W-1:0];
          CFG_COL_COUNT: col_count_r <= cfg_data[COLCNT_W-1:0];
          CFG_SAFE_MODE: safe_mode_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (issue) begin
        col_r <= col_r + 1'b1;
        if (col_last) begin
          iss_done_r <= 1'b1;
        end
      end
      case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            if (cnt_inc >= total) begin
              load_cnt_r <= '0;
              state_r    <= S_SUM;
              row_r      <= '0;
              base_r     <= '0;
              any_deg_r  <= 1'b0;
              deg_r      <= 1'b0;
              sum_r      <= '0;
              col_r      <= '0;
              iss_done_r <= 1'b0;
            end else begin
              load_cnt_r <= cnt_inc;
            end
          end
        end
        S_SUM: begin
          if (v1_r) begin
            sum_r <= sum_r + SUM_W'(rd_data_r);
            if (l1_r) begin
              state_r    <= S_DEV;
              col_r      <= '0;
              iss_done_r <= 1'b0;
              m_r        <= '0;
            end
          end
        end
        S_DEV: begin
          if (v3_r) begin
            m_r <= m_fin;
            if (l3_r) begin
              col_r      <= '0;
              iss_done_r <= 1'b0;
              right_r    <= '0;
              left_r     <= '0;
              if (m_fin == '0) begin
                deg_r     <= 1'b1;
                any_deg_r <= 1'b1;
                state_r   <= S_DIV;
              end else begin
                state_r <= S_SCALE;
              end
            end
          end
        end
        S_SCALE: begin
          if (m_r >= SC_TOP) begin
            m_r     <= m_r >> 1;
            right_r <= right_r + 1'b1;
          end else if (right_r == '0 && (m_r << 1) < SC_TOP) begin
            m_r    <= m_r << 1;
            left_r <= left_r + 1'b1;
          end else begin
            state_r    <= S_SQ;
            col_r      <= '0;
            iss_done_r <= 1'b0;
            q_r        <= '0;
          end
        end
        S_SQ: begin
          if (v5_r) begin
            q_r <= q_r + QW'(sq_r);
            if (l5_r) begin
              state_r   <= S_SQRT;
              sqrt_go_r <= 1'b1;
            end
          end
        end
        S_SQRT: begin
          if (sqrt_sts.done) begin
            norm_r     <= sqrt_root;
            state_r    <= S_DIV;
            col_r      <= '0;
            iss_done_r <= 1'b0;
          end
        end
        S_DIV: begin
          if (deg_r) begin
            col_r <= col_r + 1'b1;
            if (col_last) begin
              state_r <= S_NEXT;
            end
          end else begin
            if (issue) begin
              elem_busy_r <= 1'b1;
            end
            if (div_sts.done) begin
              elem_busy_r <= 1'b0;
              if (div_last_r) begin
                state_r <= S_NEXT;
              end
            end
          end
        end
        S_NEXT: begin
          col_r      <= '0;
          iss_done_r <= 1'b0;
          if (row_r == RI_W'(rows_eff - 1'b1)) begin
            if (any_deg_r && !safe_mode_r) begin
              state_r <= S_ERR;
            end else begin
              state_r  <= S_DOT;
              a_r      <= '0;
              b_r      <= '0;
              base_a_r <= '0;
              base_b_r <= '0;
              acc_r    <= '0;
            end
          end else begin
            row_r   <= row_r + 1'b1;
            base_r  <= base_r + ADDR_W'(cols_eff);
            deg_r   <= 1'b0;
            sum_r   <= '0;
            state_r <= S_SUM;
          end
        end
        S_DOT: begin
          if (p2_r) begin
            acc_r <= acc_r + pr_r;
            if (pl2_r) begin
              state_r <= S_FIN;
            end
          end
        end
        S_FIN: begin
          r_r     <= RW'(acc_rnd >>> FRAC_W);
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_corr_r <= corr_val;
            out_row_r  <= IDX_W'(a_r);
            out_col_r  <= IDX_W'(b_r);
            out_err_r  <= 1'b0;
            out_last_r <= pair_last;
            col_r      <= '0;
            iss_done_r <= 1'b0;
            acc_r      <= '0;
            if (pair_last) begin
              state_r <= S_LOAD;
            end else begin
              state_r <= S_DOT;
              if (b_r == RI_W'(rows_eff - 1'b1)) begin
                b_r      <= '0;
                base_b_r <= '0;
                a_r      <= a_r + 1'b1;
                base_a_r <= base_a_r + ADDR_W'(cols_eff);
              end else begin
                b_r      <= b_r + 1'b1;
                base_b_r <= base_b_r + ADDR_W'(cols_eff);
              end
            end
          end
        end
        S_ERR: begin
          if (out_free) begin
            out_corr_r <= '0;
            out_row_r  <= '0;
            out_col_r  <= '0;
            out_err_r  <= 1'b1;
            out_last_r <= 1'b1;
            state_r    <= S_LOAD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  rcm_sqrt #(
    .VAL_W (QW2)
  ) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_go_r),
    .val   (QW2'(q_r)),
    .root  (sqrt_root),
    .sts   (sqrt_sts)
  );

  rcm_div #(
    .DEN_W (NRM_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .mag   (sc_r),
    .den   (norm_r),
    .quot  (div_quot),
    .sts   (div_sts)
  );

  assign out_valid       = out_valid_r;
  assign out_correlation = out_corr_r;
  assign out_row_index   = out_row_r;
  assign out_col_index   = out_col_r;
  assign out_error_flag  = out_err_r;
  assign out_last_flag   = out_last_r;

  `RCM_ASSERT_IMP(a_err_last, out_valid && out_error_flag, out_last_flag, "error word without last")
  `RCM_ASSERT_NXT(a_out_hold, state_r == S_OUT && out_valid_r && out_stall, state_r == S_OUT, "word dropped")
  `RCM_ASSERT_IMP(a_cnt_idle, state_r != S_LOAD, load_cnt_r == '0, "load count not cleared")

endmodule

/* rtl/core/rcm_sqrt.sv */
module rcm_sqrt import rcm_pkg::*; #(
  parameter int VAL_W = 60
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [VAL_W-1:0]   val,
  output logic [VAL_W/2-1:0] root,
  output unit_sts_t          sts
);

  logic [VAL_W-1:0] v_r, r_r, bit_r;
  logic             busy_r, done_r;
  logic [VAL_W:0]   trial;
  logic             ge;

  assign trial = {1'b0, r_r} + {1'b0, bit_r};
  assign ge    = {1'b0, v_r} >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        v_r    <= val;
        r_r    <= '0;
        bit_r  <= VAL_W'(1) << (VAL_W - 2);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (ge) begin
          v_r <= v_r - trial[VAL_W-1:0];
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (bit_r == VAL_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign root     = r_r[VAL_W/2-1:0];
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

/* rtl/core/rcm_div.sv */
module rcm_div import rcm_pkg::*; #(
  parameter int DEN_W = 30
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SC_W-1:0]  mag,
  input  logic [DEN_W-1:0] den,
  output logic [UQ_W-1:0]  quot,
  output unit_sts_t        sts
);

  localparam int CNT_W = $clog2(UQ_W + 1);

  logic [DEN_W-1:0] rem_r;
  logic             nb_r;
  logic [UQ_W-1:0]  q_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DEN_W:0]   t;
  logic             ge;

  assign t  = {rem_r, nb_r};
  assign ge = t >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= DEN_W'(mag >> 1);
        nb_r   <= mag[0];
        cnt_r  <= CNT_W'(UQ_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? DEN_W'(t - {1'b0, den}) : DEN_W'(t);
        q_r   <= {q_r[UQ_W-2:0], ge};
        nb_r  <= 1'b0;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quot     = q_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import rcm_pkg::*;

  localparam int STORE_N    = MAX_ROWS_DEF * MAX_COLS_DEF;
  localparam int CYCLE_MAX  = 1000000;
  localparam int LONG_HOLD  = 400;

  typedef struct {
    logic signed [CORR_W-1:0] corr;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic                     err;
    logic                     last;
  } corr_word_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [CORR_W-1:0]   out_correlation;
  logic [IDX_W-1:0]           out_row_index;
  logic [IDX_W-1:0]           out_col_index;
  logic                       out_error_flag;
  logic                       out_last_flag;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;

  row_correlation_matrix_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_correlation (out_correlation),
    .out_row_index   (out_row_index),
    .out_col_index   (out_col_index),
    .out_error_flag  (out_error_flag),
    .out_last_flag   (out_last_flag),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  logic [31:0]  sample_q[$];
  corr_word_t   corr_q[$];

  logic [31:0]  sample_buf[STORE_N];
  longint       unit_buf[STORE_N];
  int unsigned  fill_cnt;
  logic [3:0]   rows_reg;
  logic [8:0]   cols_reg;
  logic         safe_reg;

  bit           failed;
  int unsigned  cycle_cnt;
  int unsigned  word_cnt;
  int unsigned  err_cnt;
  int unsigned  matrix_cnt;
  int unsigned  sample_cnt;

  logic         in_taken;
  int unsigned  burst_left;
  int unsigned  gap_left;
  bit           no_gaps;
  bit           hold_req;
  logic         hold_done;
  int unsigned  hold_left;
  int unsigned  stall_phase;
  int unsigned  stall_mode;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned eff_rows(logic [3:0] r);
    if (r == 0) return 1;
    if (r > MAX_ROWS_DEF) return MAX_ROWS_DEF;
    return int'(r);
  endfunction

  function automatic int unsigned eff_cols(logic [8:0] c);
    if (c == 0) return 1;
    if (c > MAX_COLS_DEF) return MAX_COLS_DEF;
    return int'(c);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // center and scale one row to unit length; return 1 when the row is flat
  function automatic bit unit_row(int unsigned row, int unsigned cols);
    longint sum;
    longint d;
    longint unsigned mag;
    longint unsigned m;
    longint unsigned q;
    longint unsigned nrm;
    int unsigned base;
    int unsigned rsh;
    int unsigned lsh;
    base = row * cols;
    sum = 0;
    m = 0;
    q = 0;
    rsh = 0;
    lsh = 0;
    for (int j = 0; j < cols; j++) sum += longint'($signed(sample_buf[base + j]));
    for (int j = 0; j < cols; j++) begin
      d = longint'(cols) * longint'($signed(sample_buf[base + j])) - sum;
      mag = (d < 0) ? -d : d;
      if (mag > m) m = mag;
      unit_buf[base + j] = d;
    end
    if (m == 0) begin
      for (int j = 0; j < cols; j++) unit_buf[base + j] = 0;
      return 1'b1;
    end
    while ((m >> rsh) >= (64'd1 << SC_W)) rsh++;
    if (rsh == 0)
      while ((m << (lsh + 1)) < (64'd1 << SC_W)) lsh++;
    for (int j = 0; j < cols; j++) begin
      d = unit_buf[base + j];
      mag = (d < 0) ? -d : d;
      mag = (mag >> rsh) << lsh;
      q += mag * mag;
      unit_buf[base + j] = (d < 0) ? -longint'(mag) : longint'(mag);
    end
    nrm = int_sqrt(q);
    for (int j = 0; j < cols; j++) begin
      d = unit_buf[base + j];
      mag = (d < 0) ? -d : d;
      mag = (mag << FRAC_W) / nrm;
      unit_buf[base + j] = (d < 0) ? -longint'(mag) : longint'(mag);
    end
    return 1'b0;
  endfunction

  function automatic longint pair_corr(int unsigned a, int unsigned b, int unsigned cols);
    longint dot;
    longint r;
    dot = 0;
    for (int j = 0; j < cols; j++) dot += unit_buf[a * cols + j] * unit_buf[b * cols + j];
    r = (dot + (ONE_Q30 >>> 1)) >>> FRAC_W;
    if (r > ONE_Q30 && r <= ONE_Q30 + EPS_Q30) r = ONE_Q30;
    else if (r < -ONE_Q30 && r >= -ONE_Q30 - EPS_Q30) r = -ONE_Q30;
    if (r > CORR_MAX) r = CORR_MAX;
    if (r < CORR_MIN) r = CORR_MIN;
    return r;
  endfunction

  // store one accepted word; on the last word of a matrix queue its correlations
  task automatic load_sample(logic [31:0] s);
    int unsigned rows;
    int unsigned cols;
    bit flat;
    corr_word_t w;
    rows = eff_rows(rows_reg);
    cols = eff_cols(cols_reg);
    if (fill_cnt < STORE_N) sample_buf[fill_cnt] = s;
    fill_cnt++;
    sample_cnt++;
    if (fill_cnt < rows * cols) return;
    fill_cnt = 0;
    matrix_cnt++;
    flat = 1'b0;
    for (int i = 0; i < rows; i++) flat |= unit_row(i, cols);
    if (flat && !safe_reg) begin
      w.corr = '0;
      w.row = '0;
      w.col = '0;
      w.err = 1'b1;
      w.last = 1'b1;
      corr_q.push_back(w);
      return;
    end
    for (int i = 0; i < rows; i++) begin
      for (int k = 0; k < rows; k++) begin
        w.corr = CORR_W'(pair_corr(i, k, cols));
        w.row = IDX_W'(i);
        w.col = IDX_W'(k);
        w.err = 1'b0;
        w.last = (i == rows - 1) && (k == rows - 1);
        corr_q.push_back(w);
      end
    end
  endtask

  // input driver
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_taken)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        in_valid <= 1'b1;
        in_sample <= sample_q[0];
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= no_gaps ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result stall pattern
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase % 64 == 0) stall_mode <= $urandom_range(0, 2);
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_req && !hold_done && out_valid) begin
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else if (stall_mode == 0) begin
      out_stall <= 1'b0;
    end else if (stall_mode == 1) begin
      out_stall <= ($urandom_range(0, 9) < 3);
    end else begin
      out_stall <= ($urandom_range(0, 9) < 7);
    end
  end

  // acceptance, result check and timeout
  always @(posedge clk) begin
    corr_word_t w;
    cycle_cnt <= cycle_cnt + 1;
    in_taken <= in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      load_sample(in_sample);
      void'(sample_q.pop_front());
    end
    if (rst_n && out_valid && !out_stall) begin
      word_cnt++;
      if (out_error_flag) err_cnt++;
      if (corr_q.size() == 0) begin
        $display("%0t: unexpected word corr=%0d row=%0d col=%0d err=%0b last=%0b",
                 $time, out_correlation, out_row_index, out_col_index,
                 out_error_flag, out_last_flag);
        failed = 1'b1;
      end else begin
        w = corr_q.pop_front();
        if (out_correlation !== w.corr) begin
          $display("%0t: correlation exp %0d got %0d (row %0d col %0d)",
                   $time, w.corr, out_correlation, w.row, w.col);
          failed = 1'b1;
        end
        if (out_row_index !== w.row) begin
          $display("%0t: row_index exp %0d got %0d", $time, w.row, out_row_index);
          failed = 1'b1;
        end
        if (out_col_index !== w.col) begin
          $display("%0t: col_index exp %0d got %0d", $time, w.col, out_col_index);
          failed = 1'b1;
        end
        if (out_error_flag !== w.err) begin
          $display("%0t: error_flag exp %0b got %0b", $time, w.err, out_error_flag);
          failed = 1'b1;
        end
        if (out_last_flag !== w.last) begin
          $display("%0t: last_flag exp %0b got %0b", $time, w.last, out_last_flag);
          failed = 1'b1;
        end
      end
    end
    if (cycle_cnt > CYCLE_MAX) begin
      $display("%0t: timeout, %0d words still expected", $time, corr_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic wait_idle();
    while (sample_q.size() > 0 || corr_q.size() > 0 || in_valid) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_ROW_COUNT: rows_reg = val[3:0];
      CFG_COL_COUNT: cols_reg = val;
      CFG_SAFE_MODE: safe_reg = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_shape(logic [3:0] r, logic [8:0] c, logic s);
    write_reg(CFG_ROW_COUNT, CFG_DATA_W'(r));
    write_reg(CFG_COL_COUNT, CFG_DATA_W'(c));
    write_reg(CFG_SAFE_MODE, CFG_DATA_W'(s));
  endtask

  // one matrix of random content; rows mix noise, near copies and flat rows
  task automatic add_matrix(int unsigned rows, int unsigned cols);
    logic [31:0] base[];
    int unsigned pick;
    logic [31:0] v;
    base = new[cols];
    for (int j = 0; j < cols; j++) base[j] = $urandom;
    for (int i = 0; i < rows; i++) begin
      pick = $urandom_range(0, 99);
      v = $urandom;
      for (int j = 0; j < cols; j++) begin
        if (pick < 3) sample_q.push_back(v);
        else if (pick < 33) sample_q.push_back($urandom);
        else if (pick < 58)
          sample_q.push_back((pick[0] ? base[j] : -base[j]) + $urandom_range(0, 2) - 1);
        else if (pick < 78) sample_q.push_back(pick[0] ? base[j] : -base[j]);
        else sample_q.push_back($urandom_range(0, 16) - 8);
      end
    end
  endtask

  initial begin
    logic [3:0] r;
    logic [8:0] c;
    int unsigned pick;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_taken = 1'b0;
    burst_left = 0;
    gap_left = 0;
    no_gaps = 1'b0;
    hold_req = 1'b0;
    hold_done = 1'b0;
    hold_left = 0;
    stall_phase = 0;
    stall_mode = 0;
    fill_cnt = 0;
    rows_reg = 4'd1;
    cols_reg = 9'd2;
    safe_reg = 1'b0;
    failed = 1'b0;
    cycle_cnt = 0;
    word_cnt = 0;
    err_cnt = 0;
    matrix_cnt = 0;
    sample_cnt = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset shape: one row of two
    sample_q.push_back(32'h7fffffff);
    sample_q.push_back(32'h80000000);
    wait_idle();
    set_shape(4'd2, 9'd3, 1'b0);
    sample_q = '{32'h7fffffff, 32'h80000000, 32'h0, 32'h1, 32'h2, 32'h3};
    wait_idle();
    sample_q = '{32'h5, 32'h5, 32'h5, 32'h1, 32'hffffffff, 32'h0};
    wait_idle();
    write_reg(CFG_SAFE_MODE, CFG_DATA_W'(1));
    sample_q = '{32'h5, 32'h5, 32'h5, 32'h1, 32'hffffffff, 32'h0};
    wait_idle();
    set_shape(4'd2, 9'd0, 1'b0);
    sample_q = '{32'h12345678, 32'h80000000};
    wait_idle();
    write_reg(CFG_SAFE_MODE, CFG_DATA_W'(1));
    sample_q = '{32'h1, 32'h2};
    wait_idle();

    set_shape(4'd1, 9'd511, 1'b0);
    add_matrix(1, MAX_COLS_DEF);
    wait_idle();

    // long receiver hold while the next matrix is already on offer
    hold_req = 1'b1;
    set_shape(4'd3, 9'd8, 1'b1);
    add_matrix(3, 8);
    add_matrix(3, 8);
    wait_idle();

    while (sample_cnt < 500) begin
      pick = $urandom_range(0, 9);
      r = (pick == 0) ? 4'd15 : (pick == 1) ? 4'd0 : 4'($urandom_range(1, 8));
      c = (pick == 2) ? 9'd0 :
          (pick == 3) ? 9'($urandom_range(1, 2)) : 9'($urandom_range(2, 12));
      no_gaps = ($urandom_range(0, 3) == 0);
      set_shape(r, c, 1'($urandom_range(0, 1)));
      repeat ($urandom_range(1, 3)) add_matrix(eff_rows(r), eff_cols(c));
      wait_idle();
    end

    $display("matrices %0d, samples %0d, result words %0d of which %0d errors",
             matrix_cnt, sample_cnt, word_cnt, err_cnt);
    $display("shapes from 1x1 to 8 rows and 256 columns, safe mode on and off");
    if (!failed && corr_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/rcm_pkg.sv
rtl/core/rcm_sqrt.sv
rtl/core/rcm_div.sv
rtl/core/row_correlation_matrix_core.sv
tb/tb_top.sv
